// File: rtl/fsp_pkg.sv
// Shared types, constants and hash and partition-count helpers for the FNV-1a string partitioner.
// No dependencies; used by every module in rtl/.
package fsp_pkg;

    localparam int HASH_W  = 64;
    localparam int BYTE_W  = 8;
    localparam int COUNT_W = 17;
    localparam int INDEX_W = 16;
    localparam int STEP_W  = 6;   // log2(HASH_W): width of the remainder step counter

    localparam logic [HASH_W-1:0]  FNV_BASIS      = 64'd2166136261;
    localparam logic [COUNT_W-1:0] MAX_PARTITIONS = 17'd65536;

    typedef struct packed {
        logic hash_fold;   // fold byte into running hash
        logic key_close;   // last word of key: latch dividend, restart hash
        logic div_step;    // one remainder step
        logic out_load;    // load result into output register
    } fsp_cmd_t;

    typedef struct packed {
        logic div_last;    // current remainder step is the final one
    } fsp_status_t;

    // (h ^ sext(b)) * 16777619 mod 2^64, prime = 2^24 + 2^8 + 2^7 + 2^4 + 2^1 + 1
    function automatic logic [HASH_W-1:0] fnv_fold(input logic [HASH_W-1:0] h,
                                                   input logic [BYTE_W-1:0] b);
        logic [HASH_W-1:0] x;
        x = h ^ {{(HASH_W-BYTE_W){b[BYTE_W-1]}}, b};
        return (x << 24) + (x << 8) + (x << 7) + (x << 4) + (x << 1) + x;
    endfunction

    // zero reads as one, anything above 65536 saturates
    function automatic logic [COUNT_W-1:0] eff_count(input logic [COUNT_W-1:0] pc);
        logic [COUNT_W-1:0] r;
        if (pc == '0) begin
            r = COUNT_W'(1);
        end else if (pc > MAX_PARTITIONS) begin
            r = MAX_PARTITIONS;
        end else begin
            r = pc;
        end
        return r;
    endfunction

endpackage

// File: rtl/fsp_datapath.sv
// Datapath: running hash, partition count register, bit-serial remainder unit
// and output data register. Depends on fsp_pkg.
module fsp_datapath (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [fsp_pkg::COUNT_W-1:0]   cfg_wr_data,
    input  logic [fsp_pkg::BYTE_W-1:0]    key_byte,
    input  logic                          byte_present,
    input  fsp_pkg::fsp_cmd_t             cmd,
    output fsp_pkg::fsp_status_t          status,
    output logic [fsp_pkg::INDEX_W-1:0]   partition_index
);

    logic [fsp_pkg::HASH_W-1:0]  hash_reg, hash_next;
    logic [fsp_pkg::HASH_W-1:0]  dividend_reg;
    logic [fsp_pkg::COUNT_W-1:0] pcount_reg;
    logic [fsp_pkg::COUNT_W-1:0] divisor_reg;
    logic [fsp_pkg::INDEX_W-1:0] rem_reg, rem_next;
    logic [fsp_pkg::STEP_W-1:0]  step_reg;
    logic [fsp_pkg::INDEX_W-1:0] index_reg;
    logic [fsp_pkg::HASH_W-1:0]  folded;
    logic [fsp_pkg::COUNT_W-1:0] trial;

    assign folded = fsp_pkg::fnv_fold(hash_reg, key_byte);

    always_comb begin
        hash_next = hash_reg;
        if (cmd.key_close) begin
            hash_next = fsp_pkg::FNV_BASIS;
        end else if (cmd.hash_fold) begin
            hash_next = folded;
        end
    end

    assign trial = {rem_reg, dividend_reg[fsp_pkg::HASH_W-1]};

    always_comb begin
        if (trial >= divisor_reg) begin
            rem_next = fsp_pkg::INDEX_W'(trial - divisor_reg);
        end else begin
            rem_next = trial[fsp_pkg::INDEX_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hash_reg   <= fsp_pkg::FNV_BASIS;
            pcount_reg <= fsp_pkg::COUNT_W'(1);
            step_reg   <= '0;
        end else begin
            hash_reg <= hash_next;
            if (cfg_wr_en) begin
                pcount_reg <= cfg_wr_data;
            end
            if (cmd.key_close) begin
                step_reg <= '0;
            end else if (cmd.div_step) begin
                step_reg <= step_reg + fsp_pkg::STEP_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.key_close) begin
            dividend_reg <= byte_present ? folded : hash_reg;
            divisor_reg  <= fsp_pkg::eff_count(pcount_reg);
            rem_reg      <= '0;
        end else if (cmd.div_step) begin
            dividend_reg <= dividend_reg << 1;
            rem_reg      <= rem_next;
        end
        if (cmd.out_load) begin
            index_reg <= rem_reg;
        end
    end

    assign status.div_last = &step_reg;
    assign partition_index = index_reg;

endmodule

// File: rtl/fsp_ctrl.sv
// Controller: handshakes, remainder sequencing and output valid flag.
// Depends on fsp_pkg.
module fsp_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic                  s_tuser,
    input  logic                  s_tlast,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output fsp_pkg::fsp_cmd_t     cmd,
    input  fsp_pkg::fsp_status_t  status
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0] state_reg, state_next;
    logic       mvalid_reg, mvalid_next;
    logic       accept;
    logic       out_free;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !mvalid_reg || m_tready;

    always_comb begin
        state_next    = state_reg;
        cmd.hash_fold = accept && s_tuser && !s_tlast;
        cmd.key_close = accept && s_tlast;
        cmd.div_step  = 1'b0;
        cmd.out_load  = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (cmd.key_close) begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (status.div_last) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        mvalid_next = mvalid_reg;
        if (cmd.out_load) begin
            mvalid_next = 1'b1;
        end else if (m_tready) begin
            mvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            mvalid_reg <= mvalid_next;
        end
    end

    assign m_tvalid = mvalid_reg;

    a_close_starts_div: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tlast) |=> (state_reg == ST_DIV))
        else $error("key end did not start remainder");

    a_last_step_in_div: assert property (@(posedge aclk) disable iff (!aresetn)
        status.div_last |-> (state_reg == ST_DIV))
        else $error("step counter out of sequence");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (mvalid_reg && !m_tready) |=> !$past(cmd.out_load))
        else $error("pending result overwritten");

endmodule

// File: rtl/fnv1a_string_partitioner.sv
// FNV-1a string partitioner. A key arrives one byte per input word
// (s_tdata byte, s_tuser = byte present, s_tlast = last word of key). Words
// without tlast leave s_tready high, so they are accepted back to back. A word
// with tlast holds s_tready low during a one-bit-per-cycle remainder of the
// 64-bit hash by the partition count and the load of the result register,
// and longer while an earlier result waits on m_tready. The partition count
// is written through cfg_wr_en/cfg_wr_data; zero acts as one and values above
// 65536 act as 65536. Depends on fsp_pkg, fsp_ctrl and fsp_datapath.
module fnv1a_string_partitioner (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [16:0] cfg_wr_data,   // partition_count
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,       // [7:0] key_byte
    input  logic        s_tuser,       // byte_present
    input  logic        s_tlast,       // key_end
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata        // [15:0] partition_index
);

    fsp_pkg::fsp_cmd_t    cmd;
    fsp_pkg::fsp_status_t status;

    fsp_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .status   (status)
    );

    fsp_datapath u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .key_byte        (s_tdata),
        .byte_present    (s_tuser),
        .cmd             (cmd),
        .status          (status),
        .partition_index (m_tdata)
    );

endmodule
